// ----- rtl/olmtf_pkg.sv -----
// Shared types and codes for the ordered list with move-to-front.
// Used by every module of the block but the RAM; depends on nothing else.
`timescale 1ns / 1ps

package olmtf_pkg;

  // Fixed field widths of the command and response beats
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MOVE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SIZE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    position;
    logic [HANDLE_W-1:0] payload_in;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic [HANDLE_W-1:0] payload_out;
    logic                last;
  } rsp_t;

  // Compare results of the shared index unit
  typedef struct packed {
    logic a_gt;   // a > b
    logic s1_gt;  // a +/- 1 > b
    logic s1_lt;  // a +/- 1 < b
    logic s2_lt;  // a +/- 2 < b
    logic s1_eq;  // a +/- 1 == b
  } step_flags_t;

endpackage

// ----- rtl/olmtf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module olmtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/olmtf_step.sv -----
// Shared index unit: steps an index by one or two, up or down, and compares
// the results against a bound. Depends on olmtf_pkg.
`timescale 1ns / 1ps

module olmtf_step #(
  parameter int CW = 6
) (
  input  logic [CW-1:0]            a,
  input  logic [CW-1:0]            b,
  input  logic                     down,
  output logic [CW-1:0]            s1,
  output logic [CW-1:0]            s2,
  output olmtf_pkg::step_flags_t   flags
);

  import olmtf_pkg::*;

  // One guard bit so a step past the bound cannot wrap
  localparam int W = CW + 1;

  logic [W-1:0] ax;
  logic [W-1:0] bx;
  logic [W-1:0] d1;
  logic [W-1:0] d2;

  assign ax = W'(a);
  assign bx = W'(b);
  assign d1 = down ? (ax - W'(1)) : (ax + W'(1));
  assign d2 = down ? (ax - W'(2)) : (ax + W'(2));

  assign s1 = d1[CW-1:0];
  assign s2 = d2[CW-1:0];

  assign flags.a_gt  = (ax > bx);
  assign flags.s1_gt = (d1 > bx);
  assign flags.s1_lt = (d1 < bx);
  assign flags.s2_lt = (d2 < bx);
  assign flags.s1_eq = (d1 == bx);

endmodule

// ----- rtl/ordered_list_move_to_front.sv -----
// Ordered list with move-to-front. A read gives one beat per cycle while the
// output does not stall. One command at a time, on a single list RAM port pair
// and a shared index unit.
// Synchronous reset empties the list; the RAM contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_move_to_front #(
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  olmtf_pkg::cmd_t   cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output olmtf_pkg::rsp_t   rsp
);

  import olmtf_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_HIT    = 4'd2;
  localparam logic [3:0] S_DEL    = 4'd3;
  localparam logic [3:0] S_MOV    = 4'd4;
  localparam logic [3:0] S_FRONT  = 4'd5;
  localparam logic [3:0] S_REVB   = 4'd6;
  localparam logic [3:0] S_REVC   = 4'd7;
  localparam logic [3:0] S_REVD   = 4'd8;
  localparam logic [3:0] S_RD     = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           idx, idx_next;
  logic [CW-1:0]           hi, hi_next;
  logic [CW-1:0]           lim, lim_next;
  logic [PAYLOAD_BITS-1:0] hit, hit_next;
  logic [PAYLOAD_BITS-1:0] tmp, tmp_next;
  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic [PAYLOAD_BITS-1:0] res_payload, res_payload_next;
  cmd_t                    cur, cur_next;
  logic                    rsp_valid_next;
  rsp_t                    rsp_next;

  // RAM port signals
  logic                    we;
  logic [AW-1:0]           wr_addr;
  logic [PAYLOAD_BITS-1:0] wr_data;
  logic [AW-1:0]           rd_addr;
  logic [PAYLOAD_BITS-1:0] rd_data;

  // Shared index unit
  logic [CW-1:0] step_b;
  logic          step_down;
  logic [CW-1:0] s1;
  logic [CW-1:0] s2;
  step_flags_t   flags;

  logic          out_free;
  logic          pos_bad;
  logic [CW-1:0] pos_idx;
  logic [CW-1:0] read_n;

  olmtf_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (DEPTH)
  ) u_list (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  olmtf_step #(
    .CW (CW)
  ) u_step (
    .a     (idx),
    .b     (step_b),
    .down  (step_down),
    .s1    (s1),
    .s2    (s2),
    .flags (flags)
  );

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Position checks on the latched command
  assign pos_bad = (cur.position == '0) || (PCW'(cur.position) > PCW'(count));
  assign pos_idx = CW'(PCW'(cur.position) - PCW'(1));
  assign read_n  = (PCW'(cur.position) < PCW'(count)) ? CW'(cur.position) : count;

  // Index unit operand select: moves walk down toward the front
  assign step_down = ((state == S_HIT) && (cur.func == FN_MOVE)) || (state == S_MOV);
  always_comb begin
    if (state == S_REVD) begin
      step_b = hi;
    end else if (state == S_RD) begin
      step_b = lim;
    end else if (step_down) begin
      step_b = '0;
    end else begin
      step_b = count;
    end
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    hi_next          = hi;
    lim_next         = lim;
    hit_next         = hit;
    tmp_next         = tmp;
    res_status_next  = res_status;
    res_payload_next = res_payload;
    cur_next         = cur;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    rsp_next         = rsp;
    we               = 1'b0;
    wr_addr          = idx[AW-1:0];
    wr_data          = rd_data;
    rd_addr          = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_next   = cmd;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_payload_next = '0;
        res_status_next  = ST_OK;
        state_next       = S_EMIT;
        case (cur.func)
          FN_APPEND: begin
            if (count == CW'(DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              we         = 1'b1;
              wr_addr    = count[AW-1:0];
              wr_data    = PAYLOAD_BITS'(cur.payload_in);
              count_next = count + CW'(1);
            end
          end
          FN_DELETE, FN_MOVE: begin
            if (pos_bad) begin
              res_status_next = ST_BAD_POS;
            end else begin
              idx_next   = pos_idx;
              rd_addr    = pos_idx[AW-1:0];
              state_next = S_HIT;
            end
          end
          FN_REVERSE: begin
            if (count > CW'(1)) begin
              idx_next   = '0;
              hi_next    = count - CW'(1);
              rd_addr    = '0;
              state_next = S_REVB;
            end
          end
          FN_SIZE: begin
            res_status_next = ST_OK;
          end
          FN_READ: begin
            if ((cur.position == '0) || (count == '0)) begin
              state_next = S_IDLE;
            end else begin
              lim_next   = read_n;
              idx_next   = '0;
              rd_addr    = '0;
              state_next = S_RD;
            end
          end
          default: begin
            res_status_next = ST_BAD_POS;
          end
        endcase
      end

      // Entry at the position is on the read port
      S_HIT: begin
        hit_next = rd_data;
        if (cur.func == FN_DELETE) begin
          if (flags.s1_lt) begin
            rd_addr    = s1[AW-1:0];
            state_next = S_DEL;
          end else begin
            count_next       = count - CW'(1);
            res_status_next  = ST_OK;
            res_payload_next = rd_data;
            state_next       = S_EMIT;
          end
        end else begin
          if (flags.a_gt) begin
            rd_addr    = s1[AW-1:0];
            state_next = S_MOV;
          end else begin
            res_status_next  = ST_OK;
            res_payload_next = rd_data;
            state_next       = S_EMIT;
          end
        end
      end

      // Close the gap: entry idx+1 moves to idx, one per cycle
      S_DEL: begin
        we       = 1'b1;
        wr_addr  = idx[AW-1:0];
        wr_data  = rd_data;
        idx_next = s1;
        if (flags.s2_lt) begin
          rd_addr = s2[AW-1:0];
        end else begin
          count_next       = count - CW'(1);
          res_status_next  = ST_OK;
          res_payload_next = hit;
          state_next       = S_EMIT;
        end
      end

      // Open the front: entry idx-1 moves to idx, one per cycle
      S_MOV: begin
        we       = 1'b1;
        wr_addr  = idx[AW-1:0];
        wr_data  = rd_data;
        idx_next = s1;
        if (flags.s1_gt) begin
          rd_addr = s2[AW-1:0];
        end else begin
          state_next = S_FRONT;
        end
      end

      S_FRONT: begin
        we               = 1'b1;
        wr_addr          = '0;
        wr_data          = hit;
        res_status_next  = ST_OK;
        res_payload_next = hit;
        state_next       = S_EMIT;
      end

      // Swap: low entry is on the read port, fetch the high one
      S_REVB: begin
        tmp_next   = rd_data;
        rd_addr    = hi[AW-1:0];
        state_next = S_REVC;
      end

      S_REVC: begin
        we         = 1'b1;
        wr_addr    = idx[AW-1:0];
        wr_data    = rd_data;
        state_next = S_REVD;
      end

      // Finish the swap and fetch the next low entry
      S_REVD: begin
        we       = 1'b1;
        wr_addr  = hi[AW-1:0];
        wr_data  = tmp;
        idx_next = s1;
        hi_next  = hi - CW'(1);
        if (flags.s2_lt) begin
          rd_addr    = s1[AW-1:0];
          state_next = S_REVB;
        end else begin
          res_status_next  = ST_OK;
          res_payload_next = '0;
          state_next       = S_EMIT;
        end
      end

      // Stream entries; the read address holds while the output stalls
      S_RD: begin
        if (out_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = ST_OK;
          rsp_next.entry_count = COUNT_W'(count);
          rsp_next.payload_out = HANDLE_W'(rd_data);
          rsp_next.last        = flags.s1_eq;
          idx_next             = s1;
          rd_addr              = s1[AW-1:0];
          if (flags.s1_eq) begin
            state_next = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = res_status;
          rsp_next.entry_count = COUNT_W'(count);
          rsp_next.payload_out = HANDLE_W'(res_payload);
          rsp_next.last        = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working registers and output beat
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    hi          <= hi_next;
    lim         <= lim_next;
    hit         <= hit_next;
    tmp         <= tmp_next;
    res_status  <= res_status_next;
    res_payload <= res_payload_next;
    cur         <= cur_next;
    rsp         <= rsp_next;
  end

endmodule

// ----- rtl/olmtf_chk.sv -----
// Port-level checks for the ordered list with move-to-front, bound to the top.
// Depends on olmtf_pkg and ordered_list_move_to_front.
`timescale 1ns / 1ps

module olmtf_chk #(
  parameter int DEPTH = 32
) (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input olmtf_pkg::rsp_t rsp
);

  import olmtf_pkg::*;

  // A command beat keeps the block busy for at least the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted on back-to-back cycles");

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // Failed operations end their command and carry no handle
  a_fail_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.last && (rsp.payload_out == '0))
    else $error("failed operation beat malformed");

  // The list never grows past its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_count <= DEPTH))
    else $error("entry count above depth");

endmodule

bind ordered_list_move_to_front olmtf_chk #(.DEPTH(DEPTH)) u_olmtf_chk (.*);

// ----- sim/ordered_list_move_to_front_test.sv -----
// Self-checking testbench for the ordered list with move-to-front.
// Drives command beats, predicts every response beat from a shadow list and checks them.
// Depends on olmtf_pkg and ordered_list_move_to_front from the rtl folder.
`timescale 1ns / 1ps

module ordered_list_move_to_front_test;
  import olmtf_pkg::*;

  localparam int LIST_DEPTH     = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest single operation is a reverse of a full list; leave margin
  localparam int SETTLE_CYCLES  = 128;
  localparam int MAX_REPORTS    = 100;

  // Selector values the block does not implement
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Shadow copy of the list and the response beats still owed by the block
  logic [HANDLE_W-1:0] shadow_list[$];
  rsp_t                expected_beats[$];

  int fail_count;
  int burst_left;
  int idle_cycles;
  int ready_hold;
  int ready_mode_cycles;
  bit ready_stalling;

  ordered_list_move_to_front #(
    .DEPTH        (LIST_DEPTH),
    .PAYLOAD_BITS (HANDLE_W)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mismatch reporting
  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic cmd_t make_cmd(input logic [FUNC_W-1:0] func,
                                    input logic [POS_W-1:0] position,
                                    input logic [HANDLE_W-1:0] handle);
    cmd_t c;
    c.func       = func;
    c.position   = position;
    c.payload_in = handle;
    return c;
  endfunction

  // Response beat carrying the list size after the operation
  function automatic rsp_t make_beat(input logic [STATUS_W-1:0] status,
                                     input logic [HANDLE_W-1:0] handle,
                                     input logic is_last);
    rsp_t b;
    b.status      = status;
    b.entry_count = COUNT_W'(shadow_list.size());
    b.payload_out = handle;
    b.last        = is_last;
    return b;
  endfunction

  // Apply one command to the shadow list and queue the beats it owes
  function automatic void apply_list_cmd(input cmd_t c);
    int                  pos;
    int                  len;
    int                  n;
    logic [HANDLE_W-1:0] hit;
    logic [HANDLE_W-1:0] swap;
    pos = c.position;
    len = shadow_list.size();
    case (c.func)
      FN_APPEND: begin
        if (len >= LIST_DEPTH) begin
          expected_beats.push_back(make_beat(ST_FULL, '0, 1'b1));
        end else begin
          shadow_list.push_back(c.payload_in);
          expected_beats.push_back(make_beat(ST_OK, '0, 1'b1));
        end
      end
      FN_DELETE, FN_MOVE: begin
        if (pos == 0 || pos > len) begin
          expected_beats.push_back(make_beat(ST_BAD_POS, '0, 1'b1));
        end else begin
          hit = shadow_list[pos-1];
          shadow_list.delete(pos-1);
          if (c.func == FN_MOVE) shadow_list.push_front(hit);
          expected_beats.push_back(make_beat(ST_OK, hit, 1'b1));
        end
      end
      FN_REVERSE: begin
        for (int i = 0; i < len / 2; i++) begin
          swap               = shadow_list[i];
          shadow_list[i]     = shadow_list[len-1-i];
          shadow_list[len-1-i] = swap;
        end
        expected_beats.push_back(make_beat(ST_OK, '0, 1'b1));
      end
      FN_SIZE: begin
        expected_beats.push_back(make_beat(ST_OK, '0, 1'b1));
      end
      FN_READ: begin
        // n above the size is clamped; n of zero owes nothing
        n = (pos > len) ? len : pos;
        for (int i = 0; i < n; i++) begin
          expected_beats.push_back(make_beat(ST_OK, shadow_list[i], i == n - 1));
        end
      end
      default: begin
        expected_beats.push_back(make_beat(ST_BAD_POS, '0, 1'b1));
      end
    endcase
  endfunction

  // Send one command beat; sender works in bursts with random gaps between them.
  // Returns right after the accepting edge; the next call or a drain settles valid.
  task automatic send_cmd(input cmd_t c);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    apply_list_cmd(c);
    burst_left--;
  endtask

  // Hold off until every owed beat has come, then let any silent operation finish
  task automatic wait_for_drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  // Position or read length: mostly in range, with edges and noise mixed in
  function automatic logic [POS_W-1:0] pick_position(input bit for_read);
    int len;
    int r;
    len = shadow_list.size();
    r   = $urandom_range(0, 9);
    if (len == 0 || r == 0) return POS_W'($urandom_range(0, 255));
    if (r == 1) return '0;
    if (r == 2) return POS_W'(len + 1);
    if (r == 3) return POS_W'(len);
    if (for_read) return POS_W'($urandom_range(1, (len < 6) ? len : 6));
    return POS_W'($urandom_range(1, len));
  endfunction

  // Operations on an empty list, plus the unused selectors
  task automatic test_empty_list();
    send_cmd(make_cmd(FN_SIZE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_READ, 8'd5, 16'h0000));
    send_cmd(make_cmd(FN_DELETE, 8'd1, 16'h0000));
    send_cmd(make_cmd(FN_MOVE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_REVERSE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_SPARE_LO, 8'd1, 16'h1234));
    send_cmd(make_cmd(FN_SPARE_HI, 8'hFF, 16'hFFFF));
  endtask

  // Each edit operation on a short list, extreme handles and positions
  task automatic test_edit_ops();
    send_cmd(make_cmd(FN_APPEND, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_APPEND, 8'hFF, 16'hFFFF));
    send_cmd(make_cmd(FN_APPEND, 8'd0, 16'hA5A5));
    send_cmd(make_cmd(FN_APPEND, 8'd0, 16'h5A5A));
    send_cmd(make_cmd(FN_APPEND, 8'd0, 16'h0001));
    send_cmd(make_cmd(FN_MOVE, 8'd3, 16'h0000));
    send_cmd(make_cmd(FN_MOVE, 8'd1, 16'h0000));
    send_cmd(make_cmd(FN_DELETE, 8'd5, 16'h0000));
    send_cmd(make_cmd(FN_DELETE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_MOVE, 8'hFF, 16'h0000));
    send_cmd(make_cmd(FN_REVERSE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_SIZE, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_READ, 8'hFF, 16'h0000));
    send_cmd(make_cmd(FN_READ, 8'd0, 16'h0000));
    send_cmd(make_cmd(FN_DELETE, 8'd1, 16'h0000));
    wait_for_drain();
  endtask

  // Fill to capacity, push past it, then work on the full list
  task automatic test_full_list();
    while (shadow_list.size() < LIST_DEPTH) begin
      send_cmd(make_cmd(FN_APPEND, pick_position(1'b0), HANDLE_W'($urandom)));
    end
    repeat (3) send_cmd(make_cmd(FN_APPEND, '0, HANDLE_W'($urandom)));
    send_cmd(make_cmd(FN_READ, POS_W'(LIST_DEPTH), '0));
    send_cmd(make_cmd(FN_REVERSE, '0, '0));
    send_cmd(make_cmd(FN_READ, 8'hFF, '0));
    send_cmd(make_cmd(FN_MOVE, POS_W'(LIST_DEPTH), '0));
    send_cmd(make_cmd(FN_DELETE, POS_W'(LIST_DEPTH), '0));
    send_cmd(make_cmd(FN_APPEND, '0, HANDLE_W'($urandom)));
    send_cmd(make_cmd(FN_READ, POS_W'(LIST_DEPTH + 1), '0));
    wait_for_drain();
  endtask

  // Random mix; alternating phases grow and shrink the list
  task automatic test_random_mix(input int items);
    bit                  growing;
    int                  r;
    int                  add_pct;
    int                  del_pct;
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    pos;
    growing = 1'b0;
    for (int k = 0; k < items; k++) begin
      if (k % 40 == 0) growing = !growing;
      add_pct = growing ? 45 : 10;
      del_pct = growing ? 8 : 40;
      r = $urandom_range(0, 99);
      if (r < add_pct) func = FN_APPEND;
      else if (r < add_pct + del_pct) func = FN_DELETE;
      else if (r < add_pct + del_pct + 15) func = FN_MOVE;
      else if (r < add_pct + del_pct + 20) func = FN_REVERSE;
      else if (r < add_pct + del_pct + 24) func = FN_SIZE;
      else if (r < add_pct + del_pct + 26) func = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
      else func = FN_READ;
      pos = (func == FN_APPEND || func == FN_REVERSE || func == FN_SIZE)
            ? POS_W'($urandom_range(0, 255)) : pick_position(func == FN_READ);
      send_cmd(make_cmd(func, pos, HANDLE_W'($urandom)));
      // Pause now and then until the block has caught up
      if (k % 97 == 96) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // Response check against the oldest owed beat
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("response beat with none expected: %h", rsp));
      end else begin
        want = expected_beats.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    rsp.entry_count, want.entry_count));
        if (rsp.payload_out !== want.payload_out)
          report_mismatch($sformatf("payload_out got %h want %h",
                                    rsp.payload_out, want.payload_out));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", rsp.last, want.last));
      end
    end
  end

  // Receiver: stalling and non-stalling stretches alternate
  always @(negedge clk) begin
    if (ready_mode_cycles == 0) begin
      ready_stalling    = !ready_stalling;
      ready_mode_cycles = $urandom_range(50, 300);
    end else begin
      ready_mode_cycles--;
    end
    if (ready_hold > 0) begin
      ready_hold--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (ready_stalling && $urandom_range(0, 3) == 0) ready_hold = $urandom_range(1, 6);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    cmd_valid         = 1'b0;
    cmd               = '0;
    rsp_ready         = 1'b0;
    fail_count        = 0;
    burst_left        = 0;
    idle_cycles       = 0;
    ready_hold        = 0;
    ready_mode_cycles = 0;
    ready_stalling    = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_random_mix(240);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
